// ===== rtl/audio_frame_sync_parser_defines.svh =====
// assertion macros for the audio frame sync parser
`ifndef AUDIO_FRAME_SYNC_PARSER_DEFINES_SVH
`define AUDIO_FRAME_SYNC_PARSER_DEFINES_SVH

// checked only out of reset
`define AFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define AFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/afs_pkg.sv =====
// types, constants and lookup tables of the audio frame sync parser
`default_nettype none
package afs_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] SYNC_HI_MASK = 8'hF0;
  localparam logic [7:0] LAYER_MASK   = 8'h06;
  localparam logic [7:0] ID3_CHAR_I   = 8'h49;
  localparam logic [7:0] ID3_CHAR_D   = 8'h44;
  localparam logic [7:0] ID3_CHAR_3   = 8'h33;
  localparam logic [1:0] LAYER_ONE    = 2'h3;
  localparam logic [28:0] ID3_HDR_LEN = 29'd10;
  localparam logic [28:0] ADTS_MIN_NOCRC = 29'd7;
  localparam logic [28:0] ADTS_MIN_CRC   = 29'd9;
  localparam logic [28:0] MP3_MIN_LEN    = 29'd4;
  localparam logic [3:0] SYNC_HDR_BYTES = 4'd6;
  localparam logic [3:0] ID3_HDR_BYTES  = 4'd10;

  localparam int MP3_SCALE_STD = 144;
  localparam int MP3_SCALE_L1  = 48;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ADTS = 2'd1,
    KIND_MP3  = 2'd2,
    KIND_ID3  = 2'd3
  } frame_kind_e;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_NO_SYNC   = 2'd3
  } status_e;

  typedef struct packed {
    frame_kind_e  kind;
    logic [28:0]  length;
    logic [16:0]  rate;
    logic [23:0]  skipped;
    status_e      status;
  } result_t;

  typedef struct packed {
    frame_kind_e  kind;
    logic [28:0]  length;
    logic [16:0]  rate;
    logic         malformed;
  } decode_t;

  // mp3 frame length without padding, by rate index, layer-one flag, bitrate index
  typedef logic [3:0][1:0][15:0][10:0] mp3_len_tab_t;

  localparam int MP3_BR [16] = '{0, 32000, 40000, 48000, 56000, 64000, 80000, 96000,
                                 112000, 128000, 160000, 192000, 224000, 256000,
                                 320000, 0};
  localparam int MP3_RATES [3] = '{44100, 48000, 32000};

  function automatic mp3_len_tab_t build_mp3_len_tab();
    mp3_len_tab_t t;
    t = '0;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 16; i++) begin
        t[r][0][i] = 11'((MP3_BR[i] * MP3_SCALE_STD) / MP3_RATES[r]);
        t[r][1][i] = 11'((MP3_BR[i] * MP3_SCALE_L1) / MP3_RATES[r]);
      end
    end
    return t;
  endfunction

  localparam mp3_len_tab_t MP3_LEN_TAB = build_mp3_len_tab();

  function automatic logic [16:0] adts_rate_hz(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] mp3_rate_hz(input logic [1:0] idx);
    logic [16:0] r;
    case (idx)
      2'd0:    r = 17'd44100;
      2'd1:    r = 17'd48000;
      2'd2:    r = 17'd32000;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // can these bytes begin an adts/mp3 or id3 header
  function automatic logic prefix_ok(input logic [3:0] len, input logic [7:0] b0,
                                     input logic [7:0] b1, input logic [7:0] b2);
    logic ok;
    if (len == 4'd0) begin
      ok = 1'b1;
    end else if (b0 == SYNC_BYTE) begin
      ok = (len < 4'd2) || ((b1 & SYNC_HI_MASK) == SYNC_HI_MASK);
    end else if (b0 == ID3_CHAR_I) begin
      ok = ((len < 4'd2) || (b1 == ID3_CHAR_D)) && ((len < 4'd3) || (b2 == ID3_CHAR_3));
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/afs_hdr_decode.sv =====
// decoder of a complete adts, mp3 or id3 header
`default_nettype none
module afs_hdr_decode
  import afs_pkg::*;
(
  input  logic [9:0][7:0] hdr_i,
  output decode_t         dec_o
);

  logic [1:0]  layer;
  logic [1:0]  mp3_ridx;
  logic [10:0] mp3_base;
  logic [28:0] min_len;

  always_comb begin
    layer    = hdr_i[1][2:1];
    mp3_ridx = hdr_i[2][3:2];
    mp3_base = MP3_LEN_TAB[mp3_ridx][layer == LAYER_ONE][hdr_i[2][7:4]];
    min_len  = MP3_MIN_LEN;
    dec_o    = '0;
    if (hdr_i[0] == SYNC_BYTE) begin
      if ((hdr_i[1] & LAYER_MASK) == 8'h00) begin
        dec_o.kind   = KIND_ADTS;
        dec_o.rate   = adts_rate_hz(hdr_i[2][5:2]);
        dec_o.length = {16'd0, hdr_i[3][1:0], hdr_i[4], hdr_i[5][7:5]};
        min_len      = hdr_i[1][0] ? ADTS_MIN_NOCRC : ADTS_MIN_CRC;
      end else begin
        dec_o.kind = KIND_MP3;
        dec_o.rate = mp3_rate_hz(mp3_ridx);
        if (dec_o.rate != 17'd0) begin
          dec_o.length = 29'(mp3_base) + 29'(hdr_i[2][1]);
        end
      end
      dec_o.malformed = (dec_o.rate == 17'd0) || (dec_o.length < min_len);
    end else begin
      dec_o.kind   = KIND_ID3;
      dec_o.length = ID3_HDR_LEN +
                     {1'b0, hdr_i[6][6:0], hdr_i[7][6:0], hdr_i[8][6:0], hdr_i[9][6:0]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/afs_out_skid.sv =====
// result register with a skid stage
`default_nettype none
module afs_out_skid
  import afs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    pop_stall_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    full_o
);

  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (!pop_stall_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_vld_q && pop_stall_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_vld_q && !pop_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (!pop_stall_i) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_vld_q && pop_stall_i) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;
  assign full_o  = skid_vld_q;

endmodule
`default_nettype wire

// ===== rtl/audio_frame_sync_parser.sv =====
// top level of the audio frame sync parser
//
//   port group   direction   handshake                 payload
//   in           to block    in_valid_i / in_stall_o   data_byte_i, buffer_end_i
//   out          from block  out_valid_o / out_stall_i frame_kind_o .. status_o
//
// one byte per cycle while in_stall_o is low; each byte is handled in the cycle it is taken and its
// result, if any, is registered into the output register or, behind a waiting result, the skid stage
// the header window, body counter and skip counter update in that same cycle
// a result arriving while another waits under out_stall_i goes to a skid stage; in_stall_o rises
// only while that skid stage is full
// reset clears the parser to hunting for a header with no bytes skipped
`default_nettype none
`include "audio_frame_sync_parser_defines.svh"
module audio_frame_sync_parser
  import afs_pkg::*;
#(
  parameter int SKIP_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_kind_o,
  output logic [28:0] frame_length_o,
  output logic [16:0] rate_hz_o,
  output logic [23:0] bytes_skipped_o,
  output logic [1:0]  status_o
);

  localparam int SKIP_W = (SKIP_BITS > 24) ? 24 : SKIP_BITS;
  localparam logic [SKIP_W:0] SKIP_MAX = {1'b0, {SKIP_W{1'b1}}};

  localparam logic MODE_SEARCH = 1'b0;
  localparam logic MODE_BODY   = 1'b1;

  logic              mode_q, mode_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        hdr_q [9];
  logic [7:0]        hdr_d [9];
  logic [28:0]       rem_q, rem_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic [1:0]        fkind_q, fkind_d;
  logic [28:0]       flen_q, flen_d;
  logic [16:0]       frate_q, frate_d;

  logic            accept;
  logic [7:0]      seq [8];
  logic [7:0]      sh [4];
  logic [3:0]      n_new;
  logic [2:0]      shift;
  logic [SKIP_W:0] skip_sum;
  logic [SKIP_W-1:0] skip_nx;
  logic [9:0][7:0] hview;
  decode_t         dec;
  logic            done;
  logic [28:0]     rem_dec, rem_new;
  logic            res_vld;
  result_t         res;
  result_t         out_data;
  logic            skid_full;

  assign accept = in_valid_i && !skid_full;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      hview[i] = (i < 9 && 4'(i) < cnt_q) ? hdr_q[(i < 9) ? i : 0] : data_byte_i;
    end
  end

  afs_hdr_decode u_dec (
    .hdr_i (hview),
    .dec_o (dec)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      seq[i] = (4'(i) < cnt_q) ? hdr_q[i] : data_byte_i;
    end
    n_new = cnt_q + 4'd1;
    // only the first few bytes can break a prefix, later ones are locked in
    shift = 3'd0;
    if (cnt_q < 4'd4) begin
      shift = n_new[2:0];
      for (int k = 3; k >= 0; k--) begin
        if (4'(k) < n_new && prefix_ok(n_new - 4'(k), seq[k], seq[k+1], seq[k+2])) begin
          shift = 3'(k);
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      sh[i] = seq[3'(i) + shift];
    end
    skip_sum = {1'b0, skip_q} + (SKIP_W + 1)'(shift);
    skip_nx  = (skip_sum > SKIP_MAX) ? SKIP_MAX[SKIP_W-1:0] : skip_sum[SKIP_W-1:0];
    done = ((cnt_q == SYNC_HDR_BYTES - 4'd1) && hdr_q[0] == SYNC_BYTE) ||
           ((cnt_q == ID3_HDR_BYTES - 4'd1) && hdr_q[0] == ID3_CHAR_I);
    rem_dec = rem_q - ((rem_q != 29'd0) ? 29'd1 : 29'd0);
    rem_new = dec.length - 29'(n_new);

    mode_d  = mode_q;
    cnt_d   = cnt_q;
    hdr_d   = hdr_q;
    rem_d   = rem_q;
    skip_d  = skip_q;
    fkind_d = fkind_q;
    flen_d  = flen_q;
    frate_d = frate_q;
    res_vld = 1'b0;
    res.kind    = frame_kind_e'(fkind_q);
    res.length  = flen_q;
    res.rate    = frate_q;
    res.skipped = 24'(skip_q);
    res.status  = ST_COMPLETE;

    if (accept) begin
      if (mode_q == MODE_BODY) begin
        rem_d = rem_dec;
        if (rem_dec == 29'd0) begin
          res_vld = 1'b1;
        end else if (buffer_end_i) begin
          res_vld    = 1'b1;
          res.status = ST_TRUNCATED;
        end
      end else begin
        skip_d      = skip_nx;
        res.skipped = 24'(skip_nx);
        if (done) begin
          res.kind   = dec.kind;
          res.length = dec.length;
          res.rate   = dec.rate;
          if (dec.malformed) begin
            res_vld    = 1'b1;
            res.status = ST_MALFORMED;
          end else if (rem_new == 29'd0) begin
            res_vld = 1'b1;
          end else if (buffer_end_i) begin
            res_vld    = 1'b1;
            res.status = ST_TRUNCATED;
          end else begin
            mode_d  = MODE_BODY;
            rem_d   = rem_new;
            fkind_d = dec.kind;
            flen_d  = dec.length;
            frate_d = dec.rate;
          end
        end else if (buffer_end_i) begin
          res_vld     = 1'b1;
          res.kind    = KIND_NONE;
          res.length  = 29'd0;
          res.rate    = 17'd0;
          res.status  = ST_NO_SYNC;
        end else begin
          cnt_d = n_new - 4'(shift);
          if (cnt_q < 4'd4) begin
            for (int i = 0; i < 4; i++) begin
              hdr_d[i] = sh[i];
            end
          end else begin
            for (int i = 4; i < 9; i++) begin
              if (4'(i) == cnt_q) begin
                hdr_d[i] = data_byte_i;
              end
            end
          end
        end
      end
      if (res_vld) begin
        mode_d  = MODE_SEARCH;
        cnt_d   = 4'd0;
        rem_d   = 29'd0;
        skip_d  = '0;
        fkind_d = KIND_NONE;
        flen_d  = 29'd0;
        frate_d = 17'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SEARCH;
      cnt_q   <= 4'd0;
      rem_q   <= 29'd0;
      skip_q  <= '0;
      fkind_q <= KIND_NONE;
      flen_q  <= 29'd0;
      frate_q <= 17'd0;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      skip_q  <= skip_d;
      fkind_q <= fkind_d;
      flen_q  <= flen_d;
      frate_q <= frate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  afs_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .pop_stall_i (out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data),
    .full_o      (skid_full)
  );

  assign in_stall_o      = skid_full;
  assign frame_kind_o    = out_data.kind;
  assign frame_length_o  = out_data.length;
  assign rate_hz_o       = out_data.rate;
  assign bytes_skipped_o = out_data.skipped;
  assign status_o        = out_data.status;

  `AFS_ASSERT(a_body_has_bytes, (mode_q == MODE_BODY) |-> (rem_q != 29'd0), "body with nothing left")
  `AFS_ASSERT(a_hdr_count, (mode_q == MODE_SEARCH) |-> (cnt_q < ID3_HDR_BYTES), "header count overrun")
  `AFS_ASSERT(a_nosync_kind, (res_vld && res.status == ST_NO_SYNC) |-> (res.kind == KIND_NONE), "no sync with a kind")
  `AFS_ASSERT_ALWAYS(a_stall_src, in_stall_o |-> out_valid_o, "stall with no result held")

endmodule
`default_nettype wire

// ===== test/tb_audio_frame_sync_parser.sv =====
// self-checking testbench for the audio frame sync parser
`timescale 1ns / 1ps
`default_nettype none
module tb_audio_frame_sync_parser;
  import afs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] length;
    logic [16:0] rate;
    logic [23:0] skipped;
    logic [1:0]  status;
  } frame_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        buffer_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  frame_kind_o;
  logic [28:0] frame_length_o;
  logic [16:0] rate_hz_o;
  logic [23:0] bytes_skipped_o;
  logic [1:0]  status_o;

  audio_frame_sync_parser dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .buffer_end_i,
    .out_valid_o, .out_stall_i, .frame_kind_o, .frame_length_o, .rate_hz_o,
    .bytes_skipped_o, .status_o
  );

  byte_word_t    pending_bytes[$];
  frame_report_t expected_reports[$];
  int            mismatches;
  bit            stimulus_done;
  int            hold_off_left;
  bit            long_hold_req;
  bit            long_hold_done;

  // parser copy
  logic [7:0]  win[10];
  int unsigned win_cnt;
  bit          in_body;
  int unsigned body_left;
  int unsigned skipped;
  logic [1:0]  fkind;
  int unsigned flen;
  int unsigned frate;

  function automatic int unsigned adts_hz(input logic [3:0] idx);
    int unsigned tab[16] = '{96000, 88200, 64000, 48000, 44100, 32000, 24000,
                             22050, 16000, 12000, 11025, 8000, 7350, 0, 0, 0};
    return tab[idx];
  endfunction

  function automatic int unsigned mp3_hz(input logic [1:0] idx);
    int unsigned tab[4] = '{44100, 48000, 32000, 0};
    return tab[idx];
  endfunction

  function automatic int unsigned mp3_bps(input logic [3:0] idx);
    int unsigned tab[16] = '{0, 32000, 40000, 48000, 56000, 64000, 80000, 96000,
                             112000, 128000, 160000, 192000, 224000, 256000,
                             320000, 0};
    return tab[idx];
  endfunction

  function automatic bit window_ok();
    if (win_cnt == 0) return 1;
    if (win[0] == SYNC_BYTE) return win_cnt < 2 || (win[1] & SYNC_HI_MASK) == SYNC_HI_MASK;
    if (win[0] == ID3_CHAR_I)
      return (win_cnt < 2 || win[1] == ID3_CHAR_D) && (win_cnt < 3 || win[2] == ID3_CHAR_3);
    return 0;
  endfunction

  task automatic report_frame(input status_e st);
    frame_report_t r;
    r.kind = fkind;
    r.length = flen[28:0];
    r.rate = frate[16:0];
    r.skipped = skipped[23:0];
    r.status = st;
    expected_reports.push_back(r);
    foreach (win[i]) win[i] = '0;
    win_cnt = 0; in_body = 0; body_left = 0; skipped = 0;
    fkind = KIND_NONE; flen = 0; frate = 0;
  endtask

  // returns 1 when the header is malformed
  function automatic bit decode_window();
    int unsigned minlen, br, scale;
    if (win[0] == SYNC_BYTE) begin
      if ((win[1] & LAYER_MASK) == 0) begin
        fkind = KIND_ADTS;
        frate = adts_hz(win[2][5:2]);
        flen = 32'({win[3][1:0], win[4], win[5][7:5]});
        minlen = win[1][0] ? 7 : 9;
      end else begin
        scale = (win[1][2:1] == LAYER_ONE) ? MP3_SCALE_L1 : MP3_SCALE_STD;
        br = mp3_bps(win[2][7:4]);
        fkind = KIND_MP3;
        frate = mp3_hz(win[2][3:2]);
        flen = 0;
        if (frate != 0) flen = (br * scale) / frate + 32'(win[2][1]);
        minlen = 4;
      end
      return frate == 0 || flen < minlen;
    end
    fkind = KIND_ID3;
    frate = 0;
    flen = 10 + 32'({win[6][6:0], win[7][6:0], win[8][6:0], win[9][6:0]});
    return 0;
  endfunction

  task automatic predict_byte(input byte_word_t w);
    bit done;
    done = 0;
    if (in_body) begin
      if (body_left > 0) body_left--;
      if (body_left == 0) report_frame(ST_COMPLETE);
      else if (w.last) report_frame(ST_TRUNCATED);
      return;
    end
    if (win_cnt < 10) begin
      win[win_cnt] = w.data;
      win_cnt++;
    end
    while (win_cnt > 0 && !window_ok()) begin
      for (int i = 0; i < 9; i++) win[i] = win[i+1];
      win[9] = '0;
      win_cnt--;
      if (skipped < 24'hFFFFFF) skipped++;
    end
    if (win_cnt == 6 && win[0] == SYNC_BYTE) done = 1;
    else if (win_cnt == 10 && win[0] == ID3_CHAR_I) done = 1;
    if (done) begin
      if (decode_window()) begin
        report_frame(ST_MALFORMED);
        return;
      end
      body_left = flen - win_cnt;
      if (body_left == 0) begin
        report_frame(ST_COMPLETE);
        return;
      end
      in_body = 1;
      if (w.last) report_frame(ST_TRUNCATED);
      return;
    end
    if (w.last) begin
      fkind = KIND_NONE; flen = 0; frate = 0;
      report_frame(ST_NO_SYNC);
    end
  endtask

  task automatic push(input logic [7:0] d, input bit l = 0);
    byte_word_t w;
    w.data = d;
    w.last = l;
    pending_bytes.push_back(w);
  endtask

  task automatic push_body(input int n, input bit end_it);
    for (int i = 0; i < n; i++) push(8'($urandom_range(0, 255)), end_it && i == n - 1);
  endtask

  // adts header with the given length, then up to len - 6 body bytes, fewer when cut is set
  task automatic push_adts(input int unsigned len, input bit cut);
    logic [7:0] b1, b2;
    b1 = 8'hF0 | ($urandom_range(0, 1) ? 8'h08 : 8'h00) | 8'($urandom_range(0, 1));
    b2 = {2'($urandom_range(0, 3)), 4'($urandom_range(0, 12)), 2'($urandom_range(0, 3))};
    push(8'hFF); push(b1); push(b2);
    push({6'($urandom_range(0, 63)), len[12:11]}); push(len[10:3]);
    push({len[2:0], 5'($urandom_range(0, 31))});
    if (len > 6)
      push_body(cut ? int'($urandom_range(1, len - 6)) : int'(len - 6), cut);
  endtask

  task automatic push_mp3(input logic [1:0] layer, input logic [3:0] bri,
                          input logic [1:0] ri, input bit pad, input int body);
    push(8'hFF); push({4'hF, 1'($urandom_range(0, 1)), layer, 1'($urandom_range(0, 1))});
    push({bri, ri, pad, 1'($urandom_range(0, 1))});
    push(8'($urandom_range(0, 255))); push(8'($urandom_range(0, 255)));
    push(8'($urandom_range(0, 255)));
    if (body > 0) push_body(body, 1);
  endtask

  task automatic push_id3(input int unsigned size, input bit high_bits, input bit cut);
    logic [7:0]  hb;
    int unsigned cap;
    hb = high_bits ? 8'h80 : 8'h00;
    // a cut tag keeps only a short piece of its body
    cap = (size < 20) ? size : 20;
    push(ID3_CHAR_I); push(ID3_CHAR_D); push(ID3_CHAR_3);
    push(8'($urandom_range(0, 255))); push(8'($urandom_range(0, 255)));
    push(8'($urandom_range(0, 255)));
    push(hb | size[27:21]); push(hb | size[20:14]); push(hb | size[13:7]);
    push(hb | size[6:0], cut && size == 0);
    if (size > 0) push_body(cut ? int'($urandom_range(1, cap)) : int'(size), cut);
  endtask

  task automatic push_noise(input int n, input bit end_it);
    for (int i = 0; i < n; i++) push(8'($urandom_range(0, 255)), end_it && i == n - 1);
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("audio_frame_sync_parser regression: fail");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      data_byte_i <= '0;
      buffer_end_i <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_byte({data_byte_i, buffer_end_i});
      if (!in_valid_i || !in_stall_o) begin
        if (pending_bytes.size() > 0 && ($urandom_range(0, 9) < 7 || hold_off_left > 0)) begin
          {data_byte_i, buffer_end_i} <= pending_bytes.pop_front();
          in_valid_i <= 1;
        end else if ($urandom_range(0, 40) == 0 && pending_bytes.size() > 0) begin
          in_valid_i <= 0;
          repeat ($urandom_range(5, 30)) @(posedge clk_i);
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    frame_report_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 0;
      hold_off_left <= 0;
      long_hold_done <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report kind %0d status %0d", frame_kind_o, status_o);
          mismatches++;
        end else begin
          exp_r = expected_reports.pop_front();
          if (frame_kind_o !== exp_r.kind) begin
            $error("frame_kind exp %0d got %0d", exp_r.kind, frame_kind_o); mismatches++;
          end
          if (frame_length_o !== exp_r.length) begin
            $error("frame_length exp %0d got %0d", exp_r.length, frame_length_o); mismatches++;
          end
          if (rate_hz_o !== exp_r.rate) begin
            $error("rate_hz exp %0d got %0d", exp_r.rate, rate_hz_o); mismatches++;
          end
          if (bytes_skipped_o !== exp_r.skipped) begin
            $error("bytes_skipped exp %0d got %0d", exp_r.skipped, bytes_skipped_o);
            mismatches++;
          end
          if (status_o !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, status_o); mismatches++;
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_stall_i <= 1;
      end else if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1;
        hold_off_left <= 200;
        out_stall_i <= 1;
      end else if ($urandom_range(0, 60) == 0) begin
        hold_off_left <= $urandom_range(10, 40);
        out_stall_i <= 1;
      end else begin
        out_stall_i <= ($urandom_range(0, 9) < 2);
      end
    end
  end

  initial begin
    int wait_cnt;
    rst_ni = 0;
    mismatches = 0;
    long_hold_req = 0;
    win_cnt = 0; in_body = 0; body_left = 0; skipped = 0;
    fkind = KIND_NONE; flen = 0; frate = 0;
    foreach (win[i]) win[i] = '0;
    in_valid_i = 0; data_byte_i = '0; buffer_end_i = 0; out_stall_i = 0;
    // directed: adts minimum, malformed, mp3 layers, id3 zero, truncation, no sync
    push_adts(7, 0);
    push_adts(3, 0);
    push(8'hFF); push(8'hF1); push(8'h34); push(8'h00); push(8'h01); push(8'h00);
    push_mp3(2'd1, 4'd1, 2'd2, 1, 1);
    push_mp3(LAYER_ONE, 4'd14, 2'd1, 0, 2);
    push_mp3(2'd2, 4'd0, 2'd0, 0, 0);
    push_mp3(2'd1, 4'd9, 2'd3, 0, 0);
    push_id3(0, 1, 0);
    push_id3(3, 0, 1);
    push(8'h52); push(8'h49); push(8'h46); push(8'h46, 1);
    push(8'hFF); push(8'hFF, 1);
    push(8'h49); push(8'h49); push(8'h44); push(8'h00, 1);
    // long hold-off so the block backs up into its input
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    for (int i = 0; i < 40; i++) push_id3(0, 0, 0);
    @(posedge clk_i);
    long_hold_req = 1;
    while (pending_bytes.size() > 20) @(posedge clk_i);
    // random
    while (pending_bytes.size() < 640) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push_adts($urandom_range(0, 30), $urandom_range(0, 3) == 0);
        3, 4: push_mp3(2'($urandom_range(1, 3)), 4'($urandom_range(0, 15)),
                       2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       int'($urandom_range(0, 3)));
        5, 6: push_id3($urandom_range(0, 1) ? $urandom_range(0, 20)
                       : $urandom_range(0, 28'hFFFFFFF), 1'($urandom_range(0, 1)), 1);
        7: push_id3($urandom_range(0, 15), 1'($urandom_range(0, 1)), 0);
        default: push_noise(int'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
      endcase
    end
    push_noise(3, 1);
    // trailing truncated frames must all end in a report
    while (pending_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    wait_cnt = 0;
    while (expected_reports.size() > 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("audio_frame_sync_parser regression: pass");
    else
      $display("audio_frame_sync_parser regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

// ===== audio_frame_sync_parser.f =====
+incdir+rtl
rtl/afs_pkg.sv
rtl/afs_hdr_decode.sv
rtl/afs_out_skid.sv
rtl/audio_frame_sync_parser.sv
test/tb_audio_frame_sync_parser.sv
